>>> rtl/core/ufsw_pkg.sv
// shared types and constants for the stop-and-wait frame sender
// no dependencies; imported by the serialiser and the top level
package ufsw_pkg;

    // default width of the millisecond timers
    localparam int TIMER_BITS_DEF = 16;
    // width of the configuration registers as written on the port
    localparam int CFG_W_MAX = 16;

    // frame layout
    localparam logic [7:0] SYNC_BYTE = 8'hA5;
    localparam int FRAME_LEN = 21;
    localparam int SEQ_POS = 2;
    localparam int ID_POS = 3;
    localparam int BODY_POS = 4;
    localparam int SUM_POS = 20;

    // register indexes
    localparam logic REG_RESEND = 1'b0;
    localparam logic REG_MAX_WAIT = 1'b1;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ONCE = 2'd1,
        OP_TICK = 2'd2,
        OP_RX   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_OK      = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    // what one input word leaves for the output side to emit
    typedef struct packed {
        logic             frame;
        logic             status;
        kind_t            status_kind;
        logic [7:0]       seq;
        logic [7:0]       id;
        logic [15:0][7:0] body;
        logic [7:0]       sum;
    } plan_t;

endpackage

>>> rtl/core/ufsw_serializer.sv
// output side: holds one plan and emits its frame bytes and status word
// one word per cycle through a registered output while out_stall is low; uses ufsw_pkg
module ufsw_serializer
    import ufsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  plan_t      plan,
    input  logic       plan_load,
    output logic       plan_free,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] out_kind,
    output logic [7:0] tx_byte,
    output logic       last
);

    localparam int IDX_W = $clog2(FRAME_LEN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] FRAME_END = IDX_W'(FRAME_LEN);

    plan_t            plan_reg;
    logic             plan_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    kind_t            out_kind_reg;
    logic [7:0]       tx_byte_reg;
    logic             last_reg;

    logic             in_frame;
    logic [IDX_W-1:0] body_off;
    logic [7:0]       frame_byte;
    kind_t            cur_kind;
    logic [7:0]       cur_byte;
    logic             cur_last;
    logic             out_load;
    logic             plan_done;

    // pick the frame byte at the current position
    always_comb
    begin
        body_off = idx_reg - IDX_W'(BODY_POS);
        case (idx_reg)
            IDX_W'(0), IDX_W'(1): frame_byte = SYNC_BYTE;
            IDX_W'(SEQ_POS):      frame_byte = plan_reg.seq;
            IDX_W'(ID_POS):       frame_byte = plan_reg.id;
            IDX_W'(SUM_POS):      frame_byte = plan_reg.sum;
            default:              frame_byte = plan_reg.body[body_off[3:0]];
        endcase
    end

    // frame bytes first, then the status word if there is one
    always_comb
    begin
        in_frame = plan_reg.frame && (idx_reg < FRAME_END);
        cur_kind = in_frame ? KIND_BYTE : plan_reg.status_kind;
        cur_byte = in_frame ? frame_byte : 8'd0;
        cur_last = in_frame ? ((idx_reg == LAST_IDX) && !plan_reg.status) : 1'b1;
    end

    assign out_load  = plan_valid_reg && (!out_valid_reg || !out_stall);
    assign plan_done = out_load && cur_last;
    assign plan_free = !plan_valid_reg || plan_done;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (plan_load)
            begin
                plan_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (out_load)
            begin
                if (cur_last)
                begin
                    plan_valid_reg <= 1'b0;
                    idx_reg        <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (plan_load)
        begin
            plan_reg <= plan;
        end
        if (out_load)
        begin
            out_kind_reg <= cur_kind;
            tx_byte_reg  <= cur_byte;
            last_reg     <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign tx_byte   = tx_byte_reg;
    assign last      = last_reg;

    // a new plan only lands in a free slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        plan_load |-> plan_free)
        else $error("plan loaded while the previous one is still open");

    // finishing a plan leaves the slot full only if another was loaded
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        plan_done |=> (plan_valid_reg == $past(plan_load)))
        else $error("plan slot wrong after the final word");

    // a status-only plan never advances the byte position
    a_status_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (plan_valid_reg && !plan_reg.frame) |-> (idx_reg == '0))
        else $error("byte position moved on a plan without a frame");

endmodule

>>> rtl/core/uart_frame_stop_and_wait_sender.sv
// top level of the stop-and-wait command frame sender
// input register, command evaluation and transaction state; uses ufsw_pkg, ufsw_serializer
//
// Each accepted command word is registered, evaluated against the transaction
// state and handed to the output serialiser, which emits one result word per
// cycle while out_stall is low: a frame is 21 words (A5 A5, sequence, id,
// sixteen little-endian command bytes, sum of bytes 2 to 19), 22 when a success
// status follows, and a status alone is one word. The first result word passes
// the input, plan and output registers in turn. The serialiser holds one plan,
// so a command waits in the input register until the final word of the previous
// plan is loaded for output; ticks and received bytes that cause no result pass
// through at one per cycle while no frame is being emitted.
// Registers resend_interval and max_wait are written through wr_en/wr_index/
// wr_data and count in tick commands, held to the lesser of TIMER_BITS and
// CFG_W_MAX bits; the elapsed counters saturate at TIMER_BITS+1 bits.
module uart_frame_stop_and_wait_sender
    import ufsw_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [7:0]           dev_id,
    input  logic [31:0]          cmd_word0,
    input  logic [31:0]          cmd_word1,
    input  logic [31:0]          cmd_word2,
    input  logic [31:0]          cmd_word3,
    input  logic [7:0]           rx_byte,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           out_kind,
    output logic [7:0]           tx_byte,
    output logic                 last,
    // configuration
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [CFG_W_MAX-1:0] wr_data
);

    localparam int CFG_W = (TIMER_BITS < CFG_W_MAX) ? TIMER_BITS : CFG_W_MAX;
    localparam int CNT_W = TIMER_BITS + 1;

    // configuration registers
    logic [CFG_W-1:0] resend_reg;
    logic [CFG_W-1:0] max_wait_reg;

    // input register
    logic             in_vld_reg;
    logic [1:0]       op_reg;
    logic [7:0]       id_reg;
    logic [15:0][7:0] body_reg;
    logic [7:0]       rx_reg;

    // transaction state
    logic [7:0]       seq_reg, seq_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] since_start_reg, since_start_next;
    logic [CNT_W-1:0] since_send_reg, since_send_next;
    logic [7:0]       last_rx_reg, last_rx_next;
    logic [7:0]       held_id_reg, held_id_next;
    logic [15:0][7:0] held_body_reg, held_body_next;

    // evaluation
    op_t              op_q;
    logic [CNT_W-1:0] start_inc;
    logic [CNT_W-1:0] send_inc;
    logic             do_frame;
    logic             timed_out;
    logic             succeeded;
    logic [7:0]       f_id;
    logic [15:0][7:0] f_body;
    plan_t            plan;
    logic             has_results;
    logic             advance;
    logic             plan_load;
    logic             plan_free;

    // wrapping sum of sequence, id and body bytes, as a short tree
    function automatic logic [7:0] frame_sum(input logic [7:0] seq,
                                             input logic [7:0] id,
                                             input logic [15:0][7:0] body);
        logic [3:0][7:0] word_sum;
        for (int k = 0; k < 4; k++)
        begin
            word_sum[k] = (body[4*k] + body[4*k+1]) + (body[4*k+2] + body[4*k+3]);
        end
        return ((word_sum[0] + word_sum[1]) + (word_sum[2] + word_sum[3])) + (seq + id);
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resend_reg   <= CFG_W'(100);
            max_wait_reg <= CFG_W'(1000);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RESEND:   resend_reg   <= wr_data[CFG_W-1:0];
                REG_MAX_WAIT: max_wait_reg <= wr_data[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // input register handshake
    assign in_stall = in_vld_reg && !plan_free;
    assign advance  = in_vld_reg && plan_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= op;
            id_reg   <= dev_id;
            body_reg <= {cmd_word3, cmd_word2, cmd_word1, cmd_word0};
            rx_reg   <= rx_byte;
        end
    end

    // saturating tick counts
    assign start_inc = (since_start_reg == '1) ? since_start_reg : since_start_reg + 1'b1;
    assign send_inc  = (since_send_reg == '1) ? since_send_reg : since_send_reg + 1'b1;

    // command evaluation against the transaction state
    always_comb
    begin
        op_q             = op_t'(op_reg);
        busy_next        = busy_reg;
        since_start_next = since_start_reg;
        since_send_next  = since_send_reg;
        last_rx_next     = last_rx_reg;
        held_id_next     = held_id_reg;
        held_body_next   = held_body_reg;
        do_frame         = 1'b0;
        timed_out        = 1'b0;
        f_id             = id_reg;
        f_body           = body_reg;

        case (op_q)
            OP_SEND:
            begin
                held_id_next     = id_reg;
                held_body_next   = body_reg;
                busy_next        = 1'b1;
                since_start_next = '0;
                since_send_next  = '0;
                do_frame         = 1'b1;
            end
            OP_ONCE:
            begin
                do_frame = 1'b1;
            end
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    since_start_next = start_inc;
                    since_send_next  = send_inc;
                    if (start_inc > CNT_W'(max_wait_reg))
                    begin
                        busy_next = 1'b0;
                        timed_out = 1'b1;
                    end
                    else if (send_inc > CNT_W'(resend_reg))
                    begin
                        do_frame        = 1'b1;
                        f_id            = held_id_reg;
                        f_body          = held_body_reg;
                        since_send_next = '0;
                    end
                end
            end
            OP_RX:
            begin
                last_rx_next = rx_reg;
            end
            default: ;
        endcase

        seq_next = do_frame ? seq_reg + 8'd1 : seq_reg;

        // acknowledgement check closes the step
        succeeded = busy_next && (last_rx_next == seq_next);
        if (succeeded)
        begin
            busy_next = 1'b0;
        end

        plan.frame       = do_frame;
        plan.status      = timed_out || succeeded;
        plan.status_kind = timed_out ? KIND_TIMEOUT : KIND_OK;
        plan.seq         = seq_next;
        plan.id          = f_id;
        plan.body        = f_body;
        plan.sum         = frame_sum(seq_next, f_id, f_body);
        has_results      = do_frame || timed_out || succeeded;
    end

    assign plan_load = advance && has_results;

    // transaction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= '0;
            busy_reg        <= 1'b0;
            since_start_reg <= '0;
            since_send_reg  <= '0;
            last_rx_reg     <= '0;
            held_id_reg     <= '0;
            held_body_reg   <= '0;
        end
        else if (advance)
        begin
            seq_reg         <= seq_next;
            busy_reg        <= busy_next;
            since_start_reg <= since_start_next;
            since_send_reg  <= since_send_next;
            last_rx_reg     <= last_rx_next;
            held_id_reg     <= held_id_next;
            held_body_reg   <= held_body_next;
        end
    end

    // output serialiser
    ufsw_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan      (plan),
        .plan_load (plan_load),
        .plan_free (plan_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .tx_byte   (tx_byte),
        .last      (last)
    );

    // a timeout always closes the transaction
    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && timed_out) |=> !busy_reg)
        else $error("transaction still open after a timeout");

endmodule
